[rtl/core/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by the checker module pip_chk.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define PIP_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next cycle.
`define PIP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/pip_pkg.sv]
// ----------------------------------------------------------------------------
// pip_pkg
// Shared command codes and sequencer states of the point-in-polygon block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pip_pkg;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIST,
    ST_DECIDE,
    ST_WALK,
    ST_DRAIN,
    ST_DONE
  } pip_state_e;

endpackage

`default_nettype wire

[rtl/core/point_in_polygon_crossing_test.sv]
// ----------------------------------------------------------------------------
// point_in_polygon_crossing_test
// Vertex store with bounding box and an even-odd ray crossing counter that
// walks the stored edges through one shared edge test pipeline.
// ----------------------------------------------------------------------------
//  channel | handshake              | word
//  --------+------------------------+----------------------------------
//  in      | in_valid_i / in_stall_o  | command_i restart_i x_i y_i
//  out     | out_valid_o / out_stall_i| inside_res_o
//
//  Load: the input stays open, the next word is taken in the following cycle.
//  Query: ST_DIST and ST_DECIDE pick the ray, ST_WALK reads the n stored
//  vertices (closing edge too for n > 2), ST_DRAIN empties the edge pipeline;
//  a point outside the box or with no ray chosen goes straight to ST_DONE. The
//  input opens as the result word appears at the output. The read port gives one vertex a cycle.
//  Reset: control state and box clear at once; the vertex memory is not cleared.
//  The result register holds a word while out_stall_i is high; loads and a
//  new query still go on, a finished query waits until that register frees.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module point_in_polygon_crossing_test
  import pip_pkg::*;
#(
  parameter int MAX_VERTICES = 64,
  parameter int COORD_BITS   = 16
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic                         command_i,
  input  wire logic                         restart_i,
  input  wire logic signed [COORD_BITS-1:0] x_i,
  input  wire logic signed [COORD_BITS-1:0] y_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic                              inside_res_o
);

  localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int CW = $clog2(MAX_VERTICES + 1);
  localparam int DW = COORD_BITS + 1;
  localparam int PW = 2 * DW;

  pip_state_e state_q, state_d;

  logic [CW-1:0] total_q;
  logic [CW-1:0] cnt_q, cnt_d;
  logic signed [COORD_BITS-1:0] box_min_x_q, box_max_x_q, box_min_y_q, box_max_y_q;
  logic signed [COORD_BITS-1:0] px_q, py_q;
  logic signed [DW-1:0] tx_q, ty_q, nx_q, ny_q;
  logic vert_q, pos_q;

  logic [2*COORD_BITS-1:0] vtx_mem [MAX_VERTICES];
  logic [2*COORD_BITS-1:0] mem_rd_q;

  logic r_vld_q, r_first_q, r_close_q;
  logic signed [COORD_BITS-1:0] first_x_q, first_y_q, prev_x_q, prev_y_q;

  logic e0_vld_q, e0_skip_q, e0_neg_q;
  logic signed [DW-1:0] e0_du_q, e0_dw_q, e0_a_q, e0_b_q;

  logic e1_vld_q, e1_skip_q, e1_neg_q;
  logic signed [PW-1:0] e1_p1_q, e1_p2_q;

  logic parity_q;
  logic out_valid_q, res_q;

  logic in_acc, load_acc, query_acc, mem_we, box_first;
  logic [AW-1:0] wr_addr;
  logic issue_rd, issue_close, out_load;
  logic dir_ok, dir_vert, dir_pos;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc    = in_valid_i && !in_stall_o;
  assign load_acc  = in_acc && (command_i == CMD_LOAD);
  assign query_acc = in_acc && (command_i == CMD_QUERY);
  assign mem_we    = load_acc && (restart_i || (total_q < CW'(MAX_VERTICES)));
  assign box_first = restart_i || (total_q == '0);
  assign wr_addr   = restart_i ? '0 : total_q[AW-1:0];

  // Nearest box side picks the ray; an x/y tie of one sign picks the y side, a max/min tie leaves no direction.
  always_comb begin
    dir_ok   = 1'b0;
    dir_vert = 1'b0;
    dir_pos  = 1'b1;
    if (tx_q < ty_q) begin
      if (tx_q < nx_q && tx_q < ny_q) begin
        dir_ok = 1'b1;
      end
    end else begin
      if (ty_q < nx_q && ty_q < ny_q) begin
        dir_ok   = 1'b1;
        dir_vert = 1'b1;
      end
    end
    if (!dir_ok) begin
      dir_pos = 1'b0;
      if (nx_q < ny_q) begin
        if (nx_q < tx_q && nx_q < ty_q) begin
          dir_ok = 1'b1;
        end
      end else begin
        if (ny_q < tx_q && ny_q < ty_q) begin
          dir_ok   = 1'b1;
          dir_vert = 1'b1;
        end
      end
    end
    if (tx_q[DW-1] || ty_q[DW-1] || nx_q[DW-1] || ny_q[DW-1]) begin
      dir_ok = 1'b0;
    end
  end

  // Sequencer
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    issue_rd    = 1'b0;
    issue_close = 1'b0;
    out_load    = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        cnt_d = '0;
        if (query_acc) begin
          state_d = ST_DIST;
        end
      end
      ST_DIST: begin
        state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        state_d = dir_ok ? ST_WALK : ST_DONE;
      end
      ST_WALK: begin
        if (cnt_q < total_q) begin
          issue_rd = 1'b1;
          cnt_d    = cnt_q + CW'(1);
        end else begin
          issue_close = (total_q > CW'(2));
          state_d     = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!(r_vld_q || e0_vld_q || e1_vld_q)) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      total_q     <= '0;
      box_min_x_q <= '0;
      box_max_x_q <= '0;
      box_min_y_q <= '0;
      box_max_y_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_load || (out_valid_q && out_stall_i);
      // a restart always writes, so the list restarts at one vertex
      if (mem_we) begin
        total_q <= (restart_i ? '0 : total_q) + CW'(1);
        if (box_first) begin
          box_min_x_q <= x_i;
          box_max_x_q <= x_i;
          box_min_y_q <= y_i;
          box_max_y_q <= y_i;
        end else begin
          if (x_i < box_min_x_q) box_min_x_q <= x_i;
          if (x_i > box_max_x_q) box_max_x_q <= x_i;
          if (y_i < box_min_y_q) box_min_y_q <= y_i;
          if (y_i > box_max_y_q) box_max_y_q <= y_i;
        end
      end
    end
  end

  // Query point, box distances and ray choice
  always_ff @(posedge clk_i) begin
    if (query_acc) begin
      px_q <= x_i;
      py_q <= y_i;
    end
    if (state_q == ST_DIST) begin
      tx_q <= {box_max_x_q[COORD_BITS-1], box_max_x_q} - {px_q[COORD_BITS-1], px_q};
      ty_q <= {box_max_y_q[COORD_BITS-1], box_max_y_q} - {py_q[COORD_BITS-1], py_q};
      nx_q <= {px_q[COORD_BITS-1], px_q} - {box_min_x_q[COORD_BITS-1], box_min_x_q};
      ny_q <= {py_q[COORD_BITS-1], py_q} - {box_min_y_q[COORD_BITS-1], box_min_y_q};
    end
    if (state_q == ST_DECIDE) begin
      vert_q <= dir_vert;
      pos_q  <= dir_pos;
    end
  end

  // Vertex memory: one write port for loads, one registered read port for the walk
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      vtx_mem[wr_addr] <= {x_i, y_i};
    end
    if (issue_rd) begin
      mem_rd_q <= vtx_mem[cnt_q[AW-1:0]];
    end
  end

  // Edge setup: current vertex against the previous one
  logic signed [COORD_BITS-1:0] cur_x, cur_y, u1, w1, u2, w2, pu, pw;
  logic signed [DW-1:0] du_c, dw_c, a_c, b_c;
  logic skip_c;

  always_comb begin
    cur_x  = r_close_q ? first_x_q : mem_rd_q[2*COORD_BITS-1:COORD_BITS];
    cur_y  = r_close_q ? first_y_q : mem_rd_q[COORD_BITS-1:0];
    u1     = vert_q ? prev_x_q : prev_y_q;
    w1     = vert_q ? prev_y_q : prev_x_q;
    u2     = vert_q ? cur_x : cur_y;
    w2     = vert_q ? cur_y : cur_x;
    pu     = vert_q ? px_q : py_q;
    pw     = vert_q ? py_q : px_q;
    du_c   = {u2[COORD_BITS-1], u2} - {u1[COORD_BITS-1], u1};
    dw_c   = {w2[COORD_BITS-1], w2} - {w1[COORD_BITS-1], w1};
    a_c    = {pu[COORD_BITS-1], pu} - {u1[COORD_BITS-1], u1};
    b_c    = {pw[COORD_BITS-1], pw} - {w1[COORD_BITS-1], w1};
    // parallel to the ray, beside the edge span, or behind the ray start
    skip_c = (u1 == u2) || (pu < u1 && pu < u2) || (pu > u1 && pu > u2) ||
             (pos_q ? (pw > w1 && pw > w2) : (pw < w1 && pw < w2));
  end

  // Cross product sign and parity
  logic signed [PW:0] diff_c;
  logic d_neg, d_pos, s_neg, s_pos, hit_c;

  always_comb begin
    diff_c = {e1_p1_q[PW-1], e1_p1_q} - {e1_p2_q[PW-1], e1_p2_q};
    d_neg  = diff_c[PW];
    d_pos  = !diff_c[PW] && (diff_c != '0);
    s_neg  = e1_neg_q ? d_pos : d_neg;
    s_pos  = e1_neg_q ? d_neg : d_pos;
    hit_c  = e1_vld_q && !e1_skip_q && (pos_q ? !s_neg : !s_pos);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_vld_q   <= 1'b0;
      r_first_q <= 1'b0;
      r_close_q <= 1'b0;
      e0_vld_q  <= 1'b0;
      e1_vld_q  <= 1'b0;
      parity_q  <= 1'b0;
    end else begin
      r_vld_q   <= issue_rd || issue_close;
      r_first_q <= issue_rd && (cnt_q == '0);
      r_close_q <= issue_close;
      e0_vld_q  <= r_vld_q && !r_first_q;
      e1_vld_q  <= e0_vld_q;
      if (query_acc) begin
        parity_q <= 1'b0;
      end else begin
        parity_q <= parity_q ^ hit_c;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (r_vld_q) begin
      prev_x_q <= cur_x;
      prev_y_q <= cur_y;
    end
    if (r_vld_q && r_first_q) begin
      first_x_q <= cur_x;
      first_y_q <= cur_y;
    end
    e0_skip_q <= skip_c;
    e0_neg_q  <= du_c[DW-1];
    e0_du_q   <= du_c;
    e0_dw_q   <= dw_c;
    e0_a_q    <= a_c;
    e0_b_q    <= b_c;
    e1_skip_q <= e0_skip_q;
    e1_neg_q  <= e0_neg_q;
    e1_p1_q   <= PW'(e0_dw_q) * PW'(e0_a_q);
    e1_p2_q   <= PW'(e0_b_q) * PW'(e0_du_q);
    if (out_load) begin
      res_q <= parity_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign inside_res_o = res_q;

endmodule

`default_nettype wire

[rtl/core/pip_chk.sv]
// ----------------------------------------------------------------------------
// pip_chk
// Port-level checks of the point-in-polygon block, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module pip_chk
  import pip_pkg::*;
(
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid_i,
  input wire logic in_stall_o,
  input wire logic command_i,
  input wire logic out_valid_o,
  input wire logic out_stall_i,
  input wire logic inside_res_o
);

  `PIP_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(inside_res_o), "stalled result word dropped or changed")
  `PIP_ASSERT_NEXT(a_load_one_cycle, clk_i, rst_ni, in_valid_i && !in_stall_o && command_i == CMD_LOAD, !in_stall_o, "load did not finish in one cycle")
  `PIP_ASSERT_NEXT(a_query_busy, clk_i, rst_ni, in_valid_i && !in_stall_o && command_i == CMD_QUERY, in_stall_o, "input taken while a query runs")
  `PIP_ASSERT_NEXT(a_no_instant_res, clk_i, rst_ni, in_valid_i && !in_stall_o && command_i == CMD_QUERY && !out_valid_o, !out_valid_o, "query answered without walking")

endmodule

bind point_in_polygon_crossing_test pip_chk u_pip_chk (.*);

`default_nettype wire
